### sv/pcx_rle_palette_decoder_core_assert.svh
// Assertion macros for the PCX run-length palette decoder.
// Each check is sampled on the rising clock edge and is held off during reset.
`ifndef PCX_RLE_PALETTE_DECODER_CORE_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks that the consequent holds in the same cycle as the antecedent.
`define PCX_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcx_rle_palette_decoder_core: same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define PCX_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcx_rle_palette_decoder_core: next-cycle check failed");
`else
`define PCX_ASSERT(lbl, ante, cons)
`define PCX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/pcxrle_pkg.sv
`timescale 1ns / 1ps

package pcxrle_pkg;

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int CFG_W  = 13;
   localparam int RUN_W  = 6;
   localparam int RGB_W  = 24;

   // Stream bytes above this value are run headers.
   localparam logic [BYTE_W-1:0] RUN_MARK   = 8'd191;
   localparam logic [BYTE_W-1:0] COUNT_MASK = 8'd63;

   // Default parameter values.
   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int MAX_DIMENSION_DEF   = 4096;

   // Reset value of both image dimension registers.
   localparam logic [CFG_W-1:0] DIM_RESET = 13'd256;

   // Register indexes of the configuration port.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Input command codes.
   localparam logic CMD_DATA    = 1'b0;
   localparam logic CMD_PALETTE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic pal_we;
      logic set_run;
      logic take_run;
      logic load_literal;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_palette;
      logic run_pending;
      logic is_header;
      logic run_len_zero;
      logic out_free;
      logic burst_done;
   } ctrl_status_type;

endpackage

### sv/pcx_rle_palette_decoder_core.sv
`timescale 1ns / 1ps
`include "pcx_rle_palette_decoder_core_assert.svh"
// PCX 8-bit run-length decoder with palette expansion.
// The req_ channel carries one beat per stream byte (req_cmd low) or per
// palette entry write (req_cmd high). The rsp_ channel returns one RGB pixel
// per beat; rsp_last_of_burst marks the last pixel caused by one request
// beat and rsp_last_of_image the last pixel of the image, after which the
// pixel count restarts. The csr_ port writes image_width (index 0) and
// image_height (index 1); it is always ready. The user must write it only while idle,
// which the block does not enforce. Palette writes and run headers produce no pixel.
// A literal byte is accepted while the palette memory is read at its
// index; the pixel is then loaded into the output register when it is free.
// A run value of count n sends up to n pixels, one at a time through the
// single output register, clipped at the image end; a zero count sends none.
// The emit sequencer holds req_stall high until the last pixel of a burst
// has been loaded. While rsp_stall is high, a valid pixel in the output
// register is held and the sequencer waits. Reset clears the pending run, the pixel
// count and the output valid and sets both dimensions to 256; the palette
// memory is not cleared and must be written before use.
module pcx_rle_palette_decoder_core
   import pcxrle_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int MAX_DIMENSION   = MAX_DIMENSION_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [BYTE_W-1:0] req_pal_index,
   input  logic [BYTE_W-1:0] req_pal_red,
   input  logic [BYTE_W-1:0] req_pal_green,
   input  logic [BYTE_W-1:0] req_pal_blue,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_red,
   output logic [BYTE_W-1:0] rsp_green,
   output logic [BYTE_W-1:0] rsp_blue,
   output logic              rsp_last_of_burst,
   output logic              rsp_last_of_image,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_data
);

   ctrl_cmd_type    dp_cmd;
   ctrl_status_type dp_status;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   // Controller: decodes each beat and sequences pixel emission.
   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Datapath: palette memory, run state, pixel count and output register.
   pcxrle_dp #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .MAX_DIMENSION   (MAX_DIMENSION)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_pal_index     (req_pal_index),
      .req_pal_red       (req_pal_red),
      .req_pal_green     (req_pal_green),
      .req_pal_blue      (req_pal_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_write         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (dp_cmd),
      .status            (dp_status)
   );

   // The last pixel of an image always closes its burst.
   `PCX_ASSERT(a_image_end_ends_burst, rsp_valid && rsp_last_of_image, rsp_last_of_burst)
   // A literal byte always blocks the input while its pixel is emitted.
   `PCX_ASSERT_NEXT(a_literal_stalls_input, dp_cmd.load_literal, req_stall)
   // The input reopens right after the final pixel of a burst is loaded.
   `PCX_ASSERT_NEXT(a_burst_end_releases, dp_cmd.emit && dp_status.burst_done, !req_stall)
   // A pixel is only loaded when the output register can take it.
   `PCX_ASSERT(a_emit_needs_slot, dp_cmd.emit, !rsp_valid || !rsp_stall)

endmodule

### sv/pcxrle_ram.sv
`timescale 1ns / 1ps

module pcxrle_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pcxrle_ctrl.sv
`timescale 1ns / 1ps

module pcxrle_ctrl
   import pcxrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic {
      S_IDLE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      take_beat;

   // Decode the accepted beat and sequence the pixel emission.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      take_beat = 1'b0;
      case (state_ff)
         S_IDLE: begin
            take_beat        = req_valid;
            cmd.pal_we       = take_beat & status.is_palette;
            cmd.take_run     = take_beat & ~status.is_palette & status.run_pending;
            cmd.set_run      = take_beat & ~status.is_palette & ~status.run_pending
                               & status.is_header;
            cmd.load_literal = take_beat & ~status.is_palette & ~status.run_pending
                               & ~status.is_header;
            if (cmd.load_literal || (cmd.take_run && !status.run_len_zero)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = status.out_free;
            if (cmd.emit && status.burst_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      stall_in = (state_in == S_EMIT);
   end

   // State and the registered input stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

### sv/pcxrle_dp.sv
`timescale 1ns / 1ps

module pcxrle_dp
   import pcxrle_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int MAX_DIMENSION   = MAX_DIMENSION_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_cmd,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [BYTE_W-1:0] req_pal_index,
   input  logic [BYTE_W-1:0] req_pal_red,
   input  logic [BYTE_W-1:0] req_pal_green,
   input  logic [BYTE_W-1:0] req_pal_blue,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_red,
   output logic [BYTE_W-1:0] rsp_green,
   output logic [BYTE_W-1:0] rsp_blue,
   output logic              rsp_last_of_burst,
   output logic              rsp_last_of_image,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_data,
   input  ctrl_cmd_type      cmd,
   output ctrl_status_type   status
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int TOT_W = 2 * DIM_W;
   localparam int AW    = $clog2(PALETTE_ENTRIES);
   localparam logic [31:0]     MAX_DIM_C = 32'(MAX_DIMENSION);
   localparam logic [BYTE_W:0] PAL_LIMIT = (BYTE_W + 1)'(PALETTE_ENTRIES);

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic              run_pending_ff, run_pending_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [BYTE_W-1:0] idx_ff, idx_in;
   logic [RUN_W-1:0]  remain_ff, remain_in;
   logic [TOT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RGB_W-1:0]  rgb_ff, rgb_in;
   logic              lob_ff, lob_in;
   logic              loi_ff, loi_in;

   logic [31:0]       width_ext, height_ext;
   logic [DIM_W-1:0]  dim_w, dim_h;
   logic [TOT_W:0]    cnt_next_full;
   logic              last_img;
   logic              idx_in_range;
   logic              wr_in_range;
   logic [AW-1:0]     ram_raddr;
   logic [RGB_W-1:0]  ram_rdata;

   // Clamp each dimension to the range one to MAX_DIMENSION.
   always_comb begin
      width_ext  = 32'(width_ff);
      height_ext = 32'(height_ff);
      if (width_ff == '0) begin
         dim_w = DIM_W'(1);
      end else if (width_ext > MAX_DIM_C) begin
         dim_w = DIM_W'(MAX_DIMENSION);
      end else begin
         dim_w = DIM_W'(width_ext);
      end
      if (height_ff == '0) begin
         dim_h = DIM_W'(1);
      end else if (height_ext > MAX_DIM_C) begin
         dim_h = DIM_W'(MAX_DIMENSION);
      end else begin
         dim_h = DIM_W'(height_ext);
      end
      total_in = TOT_W'(dim_w) * TOT_W'(dim_h);
   end

   // Palette storage, written by palette beats and read at the pixel index.
   assign wr_in_range  = ({1'b0, req_pal_index} < PAL_LIMIT);
   assign idx_in_range = ({1'b0, idx_ff} < PAL_LIMIT);
   assign ram_raddr    = (cmd.take_run || cmd.load_literal) ? req_data_byte[AW-1:0]
                                                           : idx_ff[AW-1:0];

   pcxrle_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (cmd.pal_we & wr_in_range),
      .waddr (req_pal_index[AW-1:0]),
      .wdata ({req_pal_red, req_pal_green, req_pal_blue}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Image end and burst end for the pixel now being emitted.
   assign cnt_next_full = {1'b0, cnt_ff} + (TOT_W + 1)'(1);
   assign last_img      = (cnt_next_full >= {1'b0, total_ff});

   // Status toward the controller.
   always_comb begin
      status.is_palette   = (req_cmd == CMD_PALETTE);
      status.run_pending  = run_pending_ff;
      status.is_header    = (req_data_byte > RUN_MARK);
      status.run_len_zero = (run_len_ff == '0);
      status.out_free     = ~rsp_valid_ff | ~rsp_stall;
      status.burst_done   = last_img | (remain_ff == RUN_W'(1));
   end

   // Next values of the datapath registers.
   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      run_pending_in = run_pending_ff;
      run_len_in     = run_len_ff;
      idx_in         = idx_ff;
      remain_in      = remain_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rgb_in         = rgb_ff;
      lob_in         = lob_ff;
      loi_in         = loi_ff;

      if (csr_write) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_in = csr_data;
         end else begin
            height_in = csr_data;
         end
      end

      // Run header: remember the count for the next stream byte.
      if (cmd.set_run) begin
         run_pending_in = 1'b1;
         run_len_in     = RUN_W'(req_data_byte & COUNT_MASK);
      end

      // Run value or literal: latch the index and the pixel count.
      if (cmd.take_run) begin
         run_pending_in = 1'b0;
         run_len_in     = '0;
         idx_in         = req_data_byte;
         remain_in      = run_len_ff;
      end
      if (cmd.load_literal) begin
         idx_in    = req_data_byte;
         remain_in = RUN_W'(1);
      end

      // Emit one pixel into the output register.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rgb_in       = idx_in_range ? ram_rdata : '0;
         lob_in       = status.burst_done;
         loi_in       = last_img;
         remain_in    = remain_ff - RUN_W'(1);
         cnt_in       = last_img ? '0 : cnt_next_full[TOT_W-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= DIM_RESET;
         height_ff      <= DIM_RESET;
         run_pending_ff <= 1'b0;
         run_len_ff     <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         run_pending_ff <= run_pending_in;
         run_len_ff     <= run_len_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      total_ff  <= total_in;
      idx_ff    <= idx_in;
      remain_ff <= remain_in;
      rgb_ff    <= rgb_in;
      lob_ff    <= lob_in;
      loi_ff    <= loi_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red           = rgb_ff[RGB_W-1 -: BYTE_W];
   assign rsp_green         = rgb_ff[2*BYTE_W-1 -: BYTE_W];
   assign rsp_blue          = rgb_ff[BYTE_W-1:0];
   assign rsp_last_of_burst = lob_ff;
   assign rsp_last_of_image = loi_ff;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import pcxrle_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;

   // One request beat as the block sees it.
   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] pal_index;
      logic [BYTE_W-1:0] pal_red;
      logic [BYTE_W-1:0] pal_green;
      logic [BYTE_W-1:0] pal_blue;
   } stream_beat_type;

   // One decoded pixel beat.
   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic              last_of_burst;
      logic              last_of_image;
   } pixel_beat_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic              req_cmd           = CMD_DATA;
   logic [BYTE_W-1:0] req_data_byte     = '0;
   logic [BYTE_W-1:0] req_pal_index     = '0;
   logic [BYTE_W-1:0] req_pal_red       = '0;
   logic [BYTE_W-1:0] req_pal_green     = '0;
   logic [BYTE_W-1:0] req_pal_blue      = '0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [BYTE_W-1:0] rsp_red;
   logic [BYTE_W-1:0] rsp_green;
   logic [BYTE_W-1:0] rsp_blue;
   logic              rsp_last_of_burst;
   logic              rsp_last_of_image;
   logic              csr_valid         = 1'b0;
   logic              csr_ready;
   logic              csr_index         = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]  csr_data          = '0;

   pcx_rle_palette_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_pal_index     (req_pal_index),
      .req_pal_red       (req_pal_red),
      .req_pal_green     (req_pal_green),
      .req_pal_blue      (req_pal_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // Decoder state mirrored by the testbench.
   logic [RGB_W-1:0] palette_rgb [256];
   logic             run_armed         = 1'b0;
   logic [RUN_W-1:0] run_count         = '0;
   int unsigned      image_pixels_done = 0;
   logic [CFG_W-1:0] width_reg         = DIM_RESET;
   logic [CFG_W-1:0] height_reg        = DIM_RESET;

   // Stream generation state: which palette entries hold a color, and
   // whether the last queued data byte was a run header.
   bit               pal_written [256];
   bit               gen_armed         = 1'b0;

   stream_beat_type  beat_pending [$];
   pixel_beat_type   pixel_expect [$];
   stream_beat_type  next_beat;
   int unsigned      beats_queued      = 0;
   int unsigned      beats_accepted    = 0;
   int               errors            = 0;
   int               send_idle_pct     = 0;
   int               recv_stall_pct    = 0;
   int               hold_requests     = 0;
   int               hold_served       = 0;
   int               hold_left         = 0;
   int               cycle_count       = 0;

   // A dimension register of zero counts as 1, anything above the maximum as the maximum.
   function automatic int unsigned dim_value(input logic [CFG_W-1:0] v);
      int unsigned ext;
      ext = 32'(v);
      if (ext == 0)
         return 1;
      if (ext > MAX_DIMENSION_DEF)
         return MAX_DIMENSION_DEF;
      return ext;
   endfunction

   // Queue up to count pixels of one palette index, clipped at the image end.
   function automatic void expand_pixels(input logic [BYTE_W-1:0] idx, input int unsigned count);
      int unsigned    total;
      int unsigned    n;
      logic           ended;
      pixel_beat_type px;
      total = dim_value(width_reg) * dim_value(height_reg);
      n = 0;
      ended = 1'b0;
      while (n < count && !ended) begin
         {px.red, px.green, px.blue} = palette_rgb[idx];
         px.last_of_image = (image_pixels_done + 1 >= total);
         px.last_of_burst = px.last_of_image || (n + 1 == count);
         if (px.last_of_image) begin
            image_pixels_done = 0;
            ended = 1'b1;
         end else begin
            image_pixels_done++;
         end
         pixel_expect.push_back(px);
         n++;
      end
   endfunction

   // Update the mirrored state for one accepted request beat.
   function automatic void decode_beat(input stream_beat_type b);
      int unsigned count;
      if (b.cmd == CMD_PALETTE) begin
         palette_rgb[b.pal_index] = {b.pal_red, b.pal_green, b.pal_blue};
      end else if (run_armed) begin
         count = 32'(run_count);
         run_armed = 1'b0;
         run_count = '0;
         expand_pixels(b.data_byte, count);
      end else if (b.data_byte > RUN_MARK) begin
         run_armed = 1'b1;
         run_count = b.data_byte[RUN_W-1:0];
      end else begin
         expand_pixels(b.data_byte, 1);
      end
   endfunction

   function automatic stream_beat_type random_beat();
      stream_beat_type b;
      b.cmd       = CMD_DATA;
      b.data_byte = BYTE_W'($urandom_range(255));
      b.pal_index = BYTE_W'($urandom_range(255));
      b.pal_red   = BYTE_W'($urandom_range(255));
      b.pal_green = BYTE_W'($urandom_range(255));
      b.pal_blue  = BYTE_W'($urandom_range(255));
      return b;
   endfunction

   // Stream byte beat; the unused palette fields carry random noise.
   function automatic void queue_data(input logic [BYTE_W-1:0] value);
      stream_beat_type b;
      b = random_beat();
      b.data_byte = value;
      if (gen_armed)
         gen_armed = 1'b0;
      else if (value > RUN_MARK)
         gen_armed = 1'b1;
      beat_pending.push_back(b);
      beats_queued++;
   endfunction

   // Palette write beat; the unused stream byte carries random noise.
   function automatic void queue_palette(input logic [BYTE_W-1:0] idx,
                                         input logic [BYTE_W-1:0] r,
                                         input logic [BYTE_W-1:0] g,
                                         input logic [BYTE_W-1:0] bl);
      stream_beat_type b;
      b = random_beat();
      b.cmd       = CMD_PALETTE;
      b.pal_index = idx;
      b.pal_red   = r;
      b.pal_green = g;
      b.pal_blue  = bl;
      pal_written[idx] = 1'b1;
      beat_pending.push_back(b);
      beats_queued++;
   endfunction

   function automatic void queue_random_palette();
      queue_palette(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                    BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
   endfunction

   function automatic logic [BYTE_W-1:0] run_header(input logic [RUN_W-1:0] count);
      return (RUN_MARK + 8'd1) | {2'b00, count};
   endfunction

   // Pick a palette index that already holds a color; a literal must not look like a header.
   function automatic logic [BYTE_W-1:0] pick_written(input bit literal_only);
      logic [BYTE_W-1:0] idx;
      do
         idx = BYTE_W'($urandom_range(255));
      while (!pal_written[idx] || (literal_only && idx > RUN_MARK));
      return idx;
   endfunction

   // One random stream construct: mostly literals and complete runs, some palette
   // writes, palette writes inside runs, and dangling headers closed next time.
   function automatic void queue_random_construct();
      int unsigned      pick;
      logic [RUN_W-1:0] count;
      pick = $urandom_range(99);
      if (gen_armed)
         queue_data(pick_written(1'b0));
      if (pick < 15) begin
         queue_random_palette();
      end else if (pick < 45) begin
         queue_data(pick_written(1'b1));
      end else if (pick < 93) begin
         count = ($urandom_range(3) == 0) ? RUN_W'($urandom_range(63))
                                          : RUN_W'($urandom_range(7));
         queue_data(run_header(count));
         if ($urandom_range(9) == 0)
            queue_random_palette();
         queue_data(pick_written(1'b0));
      end else begin
         queue_data(run_header(RUN_W'($urandom_range(63))));
         queue_random_palette();
      end
   endfunction

   function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function automatic void check_pixel(input pixel_beat_type got);
      pixel_beat_type want;
      if (pixel_expect.size() == 0) begin
         errors++;
         $display("%0t: unexpected pixel beat, expected none, actual %h", $time, got);
         return;
      end
      want = pixel_expect.pop_front();
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("last_of_burst", BYTE_W'(want.last_of_burst), BYTE_W'(got.last_of_burst));
      check_field("last_of_image", BYTE_W'(want.last_of_image), BYTE_W'(got.last_of_image));
   endfunction

   // Request driver: predicts each accepted beat, then offers the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_beat({req_cmd, req_data_byte, req_pal_index, req_pal_red, req_pal_green,
                         req_pal_blue});
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (beat_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = beat_pending.pop_front();
               req_cmd       <= next_beat.cmd;
               req_data_byte <= next_beat.data_byte;
               req_pal_index <= next_beat.pal_index;
               req_pal_red   <= next_beat.pal_red;
               req_pal_green <= next_beat.pal_green;
               req_pal_blue  <= next_beat.pal_blue;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: checks each accepted beat and drives the receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_pixel({rsp_red, rsp_green, rsp_blue, rsp_last_of_burst, rsp_last_of_image});
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted here so the decoder backs up into its input.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      while (beats_accepted != beats_queued || pixel_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_IMAGE_WIDTH)
         width_reg = value;
      else
         height_reg = value;
   endtask

   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input int send_pct, input int recv_pct, input int beats,
                            input bit long_hold);
      int unsigned target;
      configure(w, h);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target = beats_queued + beats;
      while (beats_queued < target)
         queue_random_construct();
      if (long_hold)
         hold_requests++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset dimensions: color extremes and patterns,
      // literals at both ends of the literal range.
      queue_palette(8'd0, 8'hFF, 8'hFF, 8'hFF);
      queue_palette(8'd255, 8'h00, 8'h00, 8'h00);
      queue_palette(8'd191, 8'h55, 8'hAA, 8'h55);
      queue_palette(8'd192, 8'hAA, 8'h55, 8'hAA);
      queue_palette(8'd85, 8'h01, 8'h80, 8'hFE);
      queue_palette(8'd170, 8'h7F, 8'h10, 8'h08);
      queue_data(8'd0);
      queue_data(8'd191);
      queue_data(8'd85);
      queue_data(8'd170);
      // Zero-length run, single-pixel run, longest run with a header-like value.
      queue_data(run_header(6'd0));
      queue_data(8'd0);
      queue_data(run_header(6'd1));
      queue_data(8'd255);
      queue_data(run_header(6'd63));
      queue_data(8'd192);
      // A palette write between a header and its value recolors that run.
      queue_data(run_header(6'd3));
      queue_palette(8'd0, 8'h01, 8'h02, 8'h03);
      queue_data(8'd0);

      // Shrink the image below the pixels already emitted, then clip runs at its end.
      configure(13'd3, 13'd2);
      queue_data(8'd85);
      queue_data(run_header(6'd63));
      queue_data(8'd170);
      queue_data(8'd0);
      queue_data(run_header(6'd8));
      queue_data(8'd191);

      // Random phases across dimension settings and idling patterns.
      run_phase(13'd0, 13'd7, 0, 0, 45, 1'b0);
      run_phase(13'd8191, 13'd1, 58, 0, 55, 1'b0);
      run_phase(13'd5, 13'd4, 0, 58, 55, 1'b0);
      run_phase(13'd4096, 13'd8191, 17, 17, 55, 1'b1);
      run_phase(13'd1, 13'd0, 17, 17, 45, 1'b0);

      wait_idle();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### pcx_rle_palette_decoder_core.f
+incdir+sv
sv/pcxrle_pkg.sv
sv/pcxrle_ram.sv
sv/pcxrle_ctrl.sv
sv/pcxrle_dp.sv
sv/pcx_rle_palette_decoder_core.sv
verif/tb.sv
